@@ hw/rtl/sblr_pkg.sv @@
`default_nettype none
package sblr_pkg;

	localparam int RADIUS_LIMIT_DEF = 63;
	localparam int RAD_W = 6;
	localparam int SUM_W = 20;
	localparam int MULT_W = 11;
	localparam int SHIFT_W = 5;
	localparam int PROD_W = SUM_W + MULT_W;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam int RAD_ENTRIES = 1 << RAD_W;

	localparam logic [ADDR_W-1:0] REG_RADIUS = 3'd0;
	localparam logic [ADDR_W-1:0] REG_FILL = 3'd4;

	typedef logic [SHIFT_W-1:0] shift_rom_t [RAD_ENTRIES];
	typedef logic [MULT_W-1:0] mult_rom_t [RAD_ENTRIES];

	typedef struct packed {
		logic [RAD_W-1:0] radius;
		logic [23:0] fill;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREFILL,
		ST_PUSH,
		ST_SUM,
		ST_TAIL,
		ST_MUL,
		ST_SHF,
		ST_OUT,
		ST_NEXT,
		ST_PASS
	} state_t;

	function automatic int calc_shift(int r);
		int d;
		int v;
		int s;
		d = (r + 1) * (r + 1);
		v = 256 * (d + 1);
		s = 0;
		while (s < 31 && (1 << s) < v)
			s++;
		return s;
	endfunction

	// ceil(2^s/d) by restoring long division
	function automatic int calc_mult(int r);
		int d;
		int n;
		int q;
		int rem;
		d = (r + 1) * (r + 1);
		n = (1 << calc_shift(r)) + d - 1;
		q = 0;
		rem = 0;
		for (int b = 30; b >= 0; b--) begin
			rem = (rem << 1) | ((n >> b) & 1);
			q = q << 1;
			if (rem >= d) begin
				rem = rem - d;
				q = q | 1;
			end
		end
		return q;
	endfunction

	function automatic shift_rom_t build_shift();
		shift_rom_t t;
		for (int r = 0; r < RAD_ENTRIES; r++)
			t[r] = SHIFT_W'(calc_shift(r));
		return t;
	endfunction

	function automatic mult_rom_t build_mult();
		mult_rom_t t;
		for (int r = 0; r < RAD_ENTRIES; r++)
			t[r] = MULT_W'(calc_mult(r));
		return t;
	endfunction

	localparam shift_rom_t SHIFT_ROM = build_shift();
	localparam mult_rom_t MULT_ROM = build_mult();

endpackage
`default_nettype wire

@@ hw/rtl/sblr_in_if.sv @@
`default_nettype none
interface sblr_in_if;
	logic valid;
	logic ready;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;
	logic [7:0] in_alpha;
	logic line_end;

	modport source (output valid, in_red, in_green, in_blue, in_alpha, line_end, input ready);
	modport sink (input valid, in_red, in_green, in_blue, in_alpha, line_end, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/sblr_out_if.sv @@
`default_nettype none
interface sblr_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [7:0] out_alpha;
	logic out_line_end;

	modport source (output valid, out_red, out_green, out_blue, out_alpha, out_line_end,
		input ready);
	modport sink (input valid, out_red, out_green, out_blue, out_alpha, out_line_end,
		output ready);
endinterface
`default_nettype wire

@@ hw/rtl/sblr_ram.sv @@
`default_nettype none
module sblr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 127
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ hw/rtl/sblr_cfg.sv @@
`default_nettype none
module sblr_cfg (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [sblr_pkg::ADDR_W-1:0] paddr,
	input wire logic [sblr_pkg::DATA_W-1:0] pwdata,
	output logic [sblr_pkg::DATA_W-1:0] prdata,
	output logic pready,
	output sblr_pkg::cfg_t cfg
);
	import sblr_pkg::*;

	cfg_t cfg_q;
	logic wr;

	assign wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radius <= RAD_W'(1);
			cfg_q.fill <= '0;
		end else if (wr) begin
			case (paddr)
				REG_RADIUS: cfg_q.radius <= pwdata[RAD_W-1:0];
				REG_FILL: cfg_q.fill <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			REG_RADIUS: prdata = DATA_W'(cfg_q.radius);
			REG_FILL: prdata = DATA_W'(cfg_q.fill);
			default: prdata = '0;
		endcase
	end
endmodule
`default_nettype wire

@@ hw/rtl/stack_blur_line_rgba.sv @@
`default_nettype none
// channel   dir  handshake              payload
// pix_in    in   valid/ready            in_red, in_green, in_blue, in_alpha, line_end
// pix_out   out  valid/ready            out_red, out_green, out_blue, out_alpha, out_line_end
// apb       in   psel/penable/pready    paddr, pwdata, prdata (radius at 0, fill at 4)
//
// one pixel passes through accept, push and next, plus, per emitted result, the
// window accumulation (one memory read per cycle), the four channels in turn on the shared
// multiplier and the output state; radius zero passes the pixel straight through
// the first pixel of a line adds r prefill writes; line_end adds r further pushes
// plus their results
// ready is high only while the sequencer is idle; a stalled output holds the
// sequencer in its output or pass-through state
// reset clears all control state; the window memory needs no clearing pass
module stack_blur_line_rgba #(
	parameter int RADIUS_LIMIT = sblr_pkg::RADIUS_LIMIT_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [sblr_pkg::ADDR_W-1:0] paddr,
	input wire logic [sblr_pkg::DATA_W-1:0] pwdata,
	output logic [sblr_pkg::DATA_W-1:0] prdata,
	output logic pready,
	sblr_in_if.sink pix_in,
	sblr_out_if.source pix_out
);
	import sblr_pkg::*;

	localparam int DEPTH = 2 * RADIUS_LIMIT + 1;
	localparam int SLOT_W = $clog2(DEPTH);
	localparam int CMP_W = 8;

	cfg_t cfg;

	sblr_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	state_t state_q, state_d;

	logic [SLOT_W-1:0] ws_q;      // slot of the newest pixel
	logic [SLOT_W-1:0] cnt_q;     // prefill count, then window tap index
	logic [RAD_W-1:0] seen_q;
	logic [RAD_W-1:0] rad_q;      // radius latched at line start
	logic [RAD_W-1:0] flush_q;    // flush pushes done on the last pixel
	logic open_q;
	logic last_q;
	logic [31:0] pix_q;           // pixel after fill replacement
	logic [31:0] raw_q;           // untouched pixel for radius zero
	logic v_s1;
	logic [6:0] w_s1;
	logic [SUM_W-1:0] sums_q [4];
	logic [1:0] ch_q;
	logic [PROD_W-1:0] prod_s1;
	logic [7:0] res_q [4];

	logic ov_q;
	logic [7:0] or_q, og_q, ob_q, oa_q;
	logic ole_q;

	// window memory
	logic ram_we, ram_re;
	logic [SLOT_W-1:0] ws_inc, rd_addr;
	logic [31:0] ram_rdata;

	sblr_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_win (
		.clk(clk), .we(ram_we), .waddr(ws_inc), .wdata(pix_q),
		.re(ram_re), .raddr(rd_addr), .rdata(ram_rdata)
	);

	logic accept;
	logic [RAD_W-1:0] rad_sat, rad_eff;
	logic [31:0] in_pix;
	logic out_free;
	logic [6:0] j7, r7, tap_dist, wgt;
	logic sum_done;
	logic [7:0] shifted;

	assign accept = pix_in.valid && pix_in.ready;
	assign pix_in.ready = (state_q == ST_IDLE);
	assign out_free = !ov_q || pix_out.ready;

	// radius saturates to the build limit
	assign rad_sat = (32'(cfg.radius) > RADIUS_LIMIT) ? RAD_W'(RADIUS_LIMIT) : cfg.radius;
	assign rad_eff = open_q ? rad_q : rad_sat;

	// alpha zero takes the fill colour
	assign in_pix = (pix_in.in_alpha == 8'd0) ? {cfg.fill, 8'd0} :
		{pix_in.in_red, pix_in.in_green, pix_in.in_blue, pix_in.in_alpha};

	assign ws_inc = (ws_q == SLOT_W'(DEPTH - 1)) ? '0 : ws_q + SLOT_W'(1);
	assign rd_addr = (ws_q >= cnt_q) ? ws_q - cnt_q :
		SLOT_W'((SLOT_W+1)'(ws_q) + (SLOT_W+1)'(DEPTH) - (SLOT_W+1)'(cnt_q));

	// triangular weight r+1-|j-r| for tap j
	assign j7 = 7'(cnt_q);
	assign r7 = 7'(rad_q);
	assign tap_dist = (j7 > r7) ? j7 - r7 : r7 - j7;
	assign wgt = r7 + 7'd1 - tap_dist;
	assign sum_done = (CMP_W'(cnt_q) == CMP_W'({rad_q, 1'b0}));

	assign shifted = 8'(prod_s1 >> SHIFT_ROM[rad_q]);

	assign ram_we = (state_q == ST_PREFILL) || (state_q == ST_PUSH);
	assign ram_re = (state_q == ST_SUM);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (rad_eff == '0)
						state_d = ST_PASS;
					else if (!open_q)
						state_d = ST_PREFILL;
					else
						state_d = ST_PUSH;
				end
			end
			ST_PREFILL: begin
				// r copies of the first pixel before its own push
				if (CMP_W'(cnt_q) + CMP_W'(1) == CMP_W'(rad_q))
					state_d = ST_PUSH;
			end
			ST_PUSH: state_d = (seen_q >= rad_q) ? ST_SUM : ST_NEXT;
			ST_SUM: if (sum_done) state_d = ST_TAIL;
			ST_TAIL: state_d = ST_MUL;
			ST_MUL: state_d = ST_SHF;
			ST_SHF: state_d = (ch_q == 2'd3) ? ST_OUT : ST_MUL;
			ST_OUT: if (out_free) state_d = ST_NEXT;
			ST_NEXT: begin
				if (last_q && flush_q != rad_q)
					state_d = ST_PUSH;
				else
					state_d = ST_IDLE;
			end
			ST_PASS: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q <= '0;
			cnt_q <= '0;
			seen_q <= '0;
			rad_q <= '0;
			flush_q <= '0;
			open_q <= 1'b0;
			last_q <= 1'b0;
			v_s1 <= 1'b0;
			ch_q <= '0;
			ov_q <= 1'b0;
			ole_q <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_SUM);
			if (pix_out.valid && pix_out.ready)
				ov_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rad_q <= rad_eff;
						last_q <= pix_in.line_end;
						flush_q <= '0;
						cnt_q <= '0;
						if (rad_eff == '0) begin
							open_q <= !pix_in.line_end;
						end else if (!open_q) begin
							seen_q <= '0;
							open_q <= 1'b1;
						end
					end
				end
				ST_PREFILL: begin
					ws_q <= ws_inc;
					cnt_q <= cnt_q + SLOT_W'(1);
				end
				ST_PUSH: begin
					ws_q <= ws_inc;
					cnt_q <= '0;
					if (seen_q < rad_q)
						seen_q <= seen_q + RAD_W'(1);
				end
				ST_SUM: if (!sum_done) cnt_q <= cnt_q + SLOT_W'(1);
				ST_TAIL: ch_q <= '0;
				ST_SHF: ch_q <= ch_q + 2'd1;
				ST_OUT: begin
					if (out_free) begin
						ov_q <= 1'b1;
						ole_q <= last_q && (flush_q == rad_q);
					end
				end
				ST_NEXT: begin
					if (last_q && flush_q != rad_q)
						flush_q <= flush_q + RAD_W'(1);
					else if (last_q)
						open_q <= 1'b0;
				end
				ST_PASS: begin
					if (out_free) begin
						ov_q <= 1'b1;
						ole_q <= last_q;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q <= in_pix;
			raw_q <= {pix_in.in_red, pix_in.in_green, pix_in.in_blue, pix_in.in_alpha};
		end
		if (state_q == ST_SUM)
			w_s1 <= wgt;
		if (state_q == ST_PUSH) begin
			for (int c = 0; c < 4; c++)
				sums_q[c] <= '0;
		end else if (v_s1) begin
			for (int c = 0; c < 4; c++)
				sums_q[c] <= sums_q[c] + SUM_W'(ram_rdata[31-8*c -: 8]) * SUM_W'(w_s1);
		end
		if (state_q == ST_MUL)
			prod_s1 <= PROD_W'(sums_q[ch_q]) * PROD_W'(MULT_ROM[rad_q]);
		if (state_q == ST_SHF)
			res_q[ch_q] <= shifted;
		if (state_q == ST_OUT && out_free) begin
			if (res_q[3] == 8'd0) begin
				or_q <= cfg.fill[23:16];
				og_q <= cfg.fill[15:8];
				ob_q <= cfg.fill[7:0];
				oa_q <= 8'd0;
			end else begin
				or_q <= res_q[0];
				og_q <= res_q[1];
				ob_q <= res_q[2];
				oa_q <= res_q[3];
			end
		end else if (state_q == ST_PASS && out_free) begin
			{or_q, og_q, ob_q, oa_q} <= raw_q;
		end
	end

	assign pix_out.valid = ov_q;
	assign pix_out.out_red = or_q;
	assign pix_out.out_green = og_q;
	assign pix_out.out_blue = ob_q;
	assign pix_out.out_alpha = oa_q;
	assign pix_out.out_line_end = ole_q;

`ifndef SYNTHESIS
	// the saturating pixel count never passes the line radius
	a_seen: assert property (@(posedge clk) disable iff (!arst_n)
		(open_q && state_q != ST_IDLE && state_q != ST_PASS) |-> (seen_q <= rad_q))
		else $error("pixels seen beyond radius");
	// window accumulation only runs with a nonzero radius
	a_sum_rad: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM) |-> (rad_q != '0))
		else $error("window sum with zero radius");
	// a result is loaded only when the output register is free
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_OUT || state_q == ST_PASS) && ov_q && !pix_out.ready) |=>
		$stable(oa_q))
		else $error("output overwritten while stalled");
`endif
endmodule
`default_nettype wire
